[hw/rtl/kn_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package kn_pkg;

  localparam int CAND_W    = 64;
  // a 64-bit value has at most 20 decimal digits
  localparam int NUM_BCD   = 20;
  localparam int BCD_W     = 4 * NUM_BCD;
  localparam int CNT_W     = 5;
  localparam int DSUM_W    = 8;
  localparam int CONV_W    = 6;
  localparam logic [CONV_W-1:0] CONV_LAST = CONV_W'(CAND_W - 1);
  localparam logic [CNT_W-1:0]  SCAN_LAST = CNT_W'(NUM_BCD - 1);

  // classified candidate handed from the front end to the recurrence engine
  typedef struct packed {
    logic [CAND_W-1:0] cand;
    logic [BCD_W-1:0]  bcd;
    logic [CNT_W-1:0]  count;
    logic [DSUM_W-1:0] dsum;
    logic              reject;
  } item_t;

endpackage

`default_nettype wire

[hw/rtl/kn_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none

interface kn_query_if;
  logic        valid;
  logic        ready;
  logic [63:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink (input valid, input candidate, output ready);
endinterface

interface kn_verdict_if;
  logic        valid;
  logic        ready;
  logic [63:0] tested_value;
  logic        is_keith;

  modport source (output valid, output tested_value, output is_keith, input ready);
  modport sink (input valid, input tested_value, input is_keith, output ready);
endinterface

`default_nettype wire

[hw/rtl/kn_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module kn_front #(
  parameter int DIGIT_LIMIT = 19
) (
  input  wire logic          clk,
  input  wire logic          rst,
  kn_query_if.sink           query,
  output kn_pkg::item_t      item,
  output logic               push,
  input  wire logic          full
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_PUSH = 2'd3;

  logic [1:0]                  state;
  logic [kn_pkg::CAND_W-1:0]   cand;
  logic [kn_pkg::CAND_W-1:0]   bin;
  logic [kn_pkg::BCD_W-1:0]    bcd;
  logic [kn_pkg::BCD_W-1:0]    adj;
  logic [kn_pkg::CONV_W-1:0]   step;
  logic [kn_pkg::CNT_W-1:0]    idx;
  logic [kn_pkg::CNT_W-1:0]    count;
  logic [kn_pkg::DSUM_W-1:0]   dsum;
  logic [3:0]                  nib;

  // double dabble add-3 correction on every digit
  always_comb begin
    for (int k = 0; k < kn_pkg::NUM_BCD; k++) begin
      adj[4*k +: 4] = (bcd[4*k +: 4] >= 4'd5) ? bcd[4*k +: 4] + 4'd3 : bcd[4*k +: 4];
    end
  end

  assign nib         = bcd[3:0];
  assign query.ready = (state == ST_IDLE);
  assign push        = (state == ST_PUSH) && !full;

  assign item.cand   = cand;
  assign item.bcd    = bcd;
  assign item.count  = count;
  assign item.dsum   = dsum;
  assign item.reject = (count == '0) || (count > kn_pkg::CNT_W'(DIGIT_LIMIT));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (query.valid) begin
            cand  <= query.candidate;
            bin   <= query.candidate;
            bcd   <= '0;
            step  <= '0;
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd  <= {adj[kn_pkg::BCD_W-2:0], bin[kn_pkg::CAND_W-1]};
          bin  <= bin << 1;
          step <= step + 1'b1;
          if (step == kn_pkg::CONV_LAST) begin
            idx   <= '0;
            dsum  <= '0;
            count <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // rotate by one digit; after a full turn the digits are back in place
          bcd  <= {bcd[3:0], bcd[kn_pkg::BCD_W-1:4]};
          dsum <= dsum + kn_pkg::DSUM_W'(nib);
          if (nib != 4'd0) begin
            count <= idx + 1'b1;
          end
          idx <= idx + 1'b1;
          if (idx == kn_pkg::SCAN_LAST) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!full) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/kn_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module kn_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire kn_pkg::item_t  wr_item,
  output logic                full,
  input  wire logic           pop,
  output kn_pkg::item_t       rd_item,
  output logic                empty
);

  kn_pkg::item_t slot [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;

  assign full    = (fill == 2'd2);
  assign empty   = (fill == 2'd0);
  assign rd_item = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/kn_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module kn_back #(
  parameter int DIGIT_LIMIT = 19
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire kn_pkg::item_t  item,
  input  wire logic           empty,
  output logic                pop,
  kn_verdict_if.source        verdict
);

  localparam int PW = (DIGIT_LIMIT > 1) ? $clog2(DIGIT_LIMIT) : 1;
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                        state;
  logic [kn_pkg::CAND_W-1:0]   cand;
  logic [kn_pkg::CAND_W-1:0]   sum;
  logic                        decided;
  logic [PW-1:0]               ptr;
  logic [PW-1:0]               last;
  logic [kn_pkg::CAND_W-1:0]   win [DIGIT_LIMIT];
  logic                        out_valid;
  logic [kn_pkg::CAND_W-1:0]   out_value;
  logic                        out_keith;

  logic [kn_pkg::CAND_W-1:0]   old;
  logic [kn_pkg::CAND_W:0]     diff;
  logic                        fin;
  logic                        res;
  logic                        out_free;
  logic                        finish;
  logic                        advance;

  assign old      = win[ptr];
  assign diff     = {sum, 1'b0} - {1'b0, old};
  assign fin      = decided || (sum >= cand);
  assign res      = !decided && (sum == cand);
  assign out_free = !out_valid || verdict.ready;
  assign finish   = (state == ST_RUN) && fin && out_free;
  assign advance  = (state == ST_RUN) && !fin;
  assign pop      = (state == ST_IDLE) && !empty;

  assign verdict.valid        = out_valid;
  assign verdict.tested_value = out_value;
  assign verdict.is_keith     = out_keith;

  // window storage, no reset
  always_ff @(posedge clk) begin
    if (pop) begin
      for (int j = 0; j < DIGIT_LIMIT; j++) begin
        win[j] <= kn_pkg::CAND_W'(item.bcd[4*j +: 4]);
      end
    end else if (advance && !diff[kn_pkg::CAND_W]) begin
      win[ptr] <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cand <= item.cand;
      sum  <= kn_pkg::CAND_W'(item.dsum);
      ptr  <= PW'(item.count - 1'b1);
      last <= PW'(item.count - 1'b1);
    end else if (advance && !diff[kn_pkg::CAND_W]) begin
      sum <= diff[kn_pkg::CAND_W-1:0];
      ptr <= (ptr == '0) ? last : ptr - 1'b1;
    end
    if (finish) begin
      out_value <= cand;
      out_keith <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      decided   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (pop) begin
            decided <= item.reject;
            state   <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (advance && diff[kn_pkg::CAND_W]) begin
            // sum ran past 64 bits, so it is above every candidate
            decided <= 1'b1;
          end
          if (finish) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (finish) begin
        out_valid <= 1'b1;
      end else if (verdict.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) && !decided |-> ptr <= last)
    else $error("window pointer beyond digit count");

  a_pop_starts_run: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == ST_RUN))
    else $error("popped item did not start the recurrence");

  a_keith_not_rejected: assert property (@(posedge clk) disable iff (rst)
    finish && res |-> !decided && (sum == cand))
    else $error("positive verdict on a rejected candidate");

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) && fin && !out_free |=> (state == ST_RUN) && $stable(sum))
    else $error("recurrence moved while the verdict was blocked");

endmodule

`default_nettype wire

[hw/rtl/keith_number_test.sv]
`timescale 1ns / 1ps
`default_nettype none

// flow: the front end takes the query transaction, converts the candidate to
//   decimal with one shift per candidate bit, scans the 20 digits and pushes
//   the item; the recurrence engine then runs its sum steps over the window
// overlap: front and back work on different candidates through the queue
// reset: rst (synchronous) empties the queue and idles both engines

module keith_number_test #(
  parameter int DIGIT_LIMIT = 19
) (
  input  wire logic      clk,
  input  wire logic      rst,
  kn_query_if.sink       query,
  kn_verdict_if.source   verdict
);

  // classified candidate leaving the front end
  kn_pkg::item_t front_item;
  // oldest queued candidate for the recurrence engine
  kn_pkg::item_t back_item;
  logic          push;
  logic          full;
  logic          pop;
  logic          empty;

  // front end: takes the query transaction, converts the candidate to decimal
  // one bit per cycle, then counts the digits and sums them one digit per cycle
  kn_front #(
    .DIGIT_LIMIT (DIGIT_LIMIT)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .query (query),
    .item  (front_item),
    .push  (push),
    .full  (full)
  );

  // two-entry queue so the front end can classify the next candidate while
  // the recurrence engine is still stepping or waiting on the verdict
  kn_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (front_item),
    .full    (full),
    .pop     (pop),
    .rd_item (back_item),
    .empty   (empty)
  );

  // recurrence engine: one sum step per cycle over the digit window, result
  // held in an output register until the verdict transaction completes
  kn_back #(
    .DIGIT_LIMIT (DIGIT_LIMIT)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .item    (back_item),
    .empty   (empty),
    .pop     (pop),
    .verdict (verdict)
  );

endmodule

`default_nettype wire

[verif/keith_verdict_checker.sv]
`timescale 1ns / 1ps

module keith_verdict_checker #(
  parameter int DIGIT_LIMIT = 19
) (
  input  logic   clk,
  input  logic   rst,
  kn_query_if    query,
  kn_verdict_if  verdict,
  output int     mismatches,
  output int     pending,
  output int     checked,
  output int     keith_hits
);

  localparam logic [kn_pkg::CAND_W-1:0] DECIMAL = 10;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [kn_pkg::CAND_W-1:0] value;
    logic                      keith;
  } verdict_t;

  verdict_t expected_verdicts[$];

  initial begin
    mismatches = 0;
    pending    = 0;
    checked    = 0;
    keith_hits = 0;
  end

  // digit recurrence, sum held two bits wider so a step past 64 bits is seen
  function automatic logic keith_recurrence_hits(input logic [kn_pkg::CAND_W-1:0] cand);
    logic [kn_pkg::CAND_W-1:0] terms [0:DIGIT_LIMIT-1];
    logic [kn_pkg::CAND_W-1:0] rest;
    logic [kn_pkg::CAND_W+1:0] total;
    logic [kn_pkg::CAND_W+1:0] next_total;
    int ndig;
    int idx;
    int oldest;
    begin
      if (cand == 0) return 1'b0;
      ndig = 0;
      rest = cand;
      while (rest != 0) begin
        ndig++;
        rest = rest / DECIMAL;
      end
      if (ndig > DIGIT_LIMIT) return 1'b0;
      // leading digit ends up in terms[0]
      rest  = cand;
      total = '0;
      for (idx = ndig - 1; idx >= 0; idx--) begin
        terms[idx] = rest % DECIMAL;
        total      = total + terms[idx];
        rest       = rest / DECIMAL;
      end
      oldest = 0;
      while (total < cand) begin
        next_total = (total << 1) - terms[oldest];
        if (next_total[kn_pkg::CAND_W+1:kn_pkg::CAND_W] != 2'b00) return 1'b0;
        terms[oldest] = total[kn_pkg::CAND_W-1:0];
        total         = next_total;
        oldest        = (oldest + 1 >= ndig) ? 0 : oldest + 1;
      end
      return total == cand;
    end
  endfunction

  task automatic report(input string msg);
    begin
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("%0t mismatch: %s", $time, msg);
    end
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      expected_verdicts.delete();
    end else begin
      if (verdict.valid && verdict.ready) begin
        checked++;
        if (verdict.is_keith) keith_hits++;
        if (expected_verdicts.size() == 0) begin
          report($sformatf("verdict with nothing pending: value %0d is_keith %0b",
                           verdict.tested_value, verdict.is_keith));
        end else begin
          want = expected_verdicts.pop_front();
          if (verdict.tested_value !== want.value)
            report($sformatf("tested_value expected %0d got %0d",
                             want.value, verdict.tested_value));
          if (verdict.is_keith !== want.keith)
            report($sformatf("is_keith for %0d expected %0b got %0b",
                             want.value, want.keith, verdict.is_keith));
        end
      end
      if (query.valid && query.ready) begin
        want.value = query.candidate;
        want.keith = keith_recurrence_hits(query.candidate);
        expected_verdicts.push_back(want);
      end
    end
    pending <= expected_verdicts.size();
  end

endmodule

[verif/keith_number_test_tb.sv]
`timescale 1ns / 1ps

module keith_number_test_tb;

  localparam int DIGIT_LIMIT  = 19;
  localparam int RANDOM_ITEMS = 400;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 250;
  localparam int NUM_DIRECTED = 22;
  localparam int NUM_KEITH    = 24;

  logic clk;
  logic rst;

  // idle percentages, changed between phases
  int send_idle_pct;
  int recv_idle_pct;

  int cycle_count;
  int sent;
  int wide_sent;
  int mismatches;
  int pending;
  int checked;
  int keith_hits;

  kn_query_if   query_ch ();
  kn_verdict_if verdict_ch ();

  keith_number_test #(.DIGIT_LIMIT(DIGIT_LIMIT)) dut (
    .clk     (clk),
    .rst     (rst),
    .query   (query_ch),
    .verdict (verdict_ch)
  );

  keith_verdict_checker #(.DIGIT_LIMIT(DIGIT_LIMIT)) verdict_chk (
    .clk        (clk),
    .rst        (rst),
    .query      (query_ch),
    .verdict    (verdict_ch),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked),
    .keith_hits (keith_hits)
  );

  // corner candidates: zero, single digits, small keith numbers and their
  // neighbors, the 19 digit limit and 20 digit values that must be rejected
  logic [63:0] directed_cands [0:NUM_DIRECTED-1] = '{
    64'd0, 64'd1, 64'd5, 64'd9, 64'd10, 64'd14, 64'd15, 64'd99,
    64'd197, 64'd742, 64'd7385, 64'd7386, 64'd129572008, 64'd251133297,
    64'd251133296, 64'd1000000000000000000, 64'd9999999999999999999,
    64'd10000000000000000000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
    64'h7FFF_FFFF_FFFF_FFFF, 64'd1234567890123456789
  };

  // known hits, used so the random part sees true verdicts now and then
  logic [63:0] keith_table [0:NUM_KEITH-1] = '{
    64'd14, 64'd19, 64'd28, 64'd47, 64'd61, 64'd75, 64'd197, 64'd742,
    64'd1104, 64'd1537, 64'd2208, 64'd2580, 64'd3684, 64'd4788, 64'd7385,
    64'd7647, 64'd7909, 64'd31331, 64'd34285, 64'd129106, 64'd1084051,
    64'd11436171, 64'd129572008, 64'd251133297
  };

  // clock, 8 ns period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // receiver side: ready redrawn every falling edge
  always @(negedge clk) begin
    verdict_ch.ready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // watchdog: a hung block ends the run here
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [63:0] random_candidate();
    int kind;
    int ndig;
    logic [63:0] lo;
    logic [63:0] pick;
    begin
      kind = $urandom_range(0, 99);
      pick = {$urandom, $urandom};
      if (kind < 15) begin
        random_candidate = keith_table[$urandom_range(0, NUM_KEITH - 1)];
      end else if (kind < 25) begin
        // one off a hit: the recurrence overshoots
        random_candidate = keith_table[$urandom_range(0, NUM_KEITH - 1)]
                           + ($urandom_range(0, 1) ? 64'd1 : -64'd1);
      end else if (kind < 37) begin
        // whole field, about half of it 20 digits, every bit toggles
        random_candidate = pick;
      end else if (kind < 47) begin
        // 19 digits, where the sum can step past 64 bits
        random_candidate = 64'd1000000000000000000 + pick % 64'd9000000000000000000;
      end else if (kind < 49) begin
        random_candidate = 64'd0;
      end else begin
        ndig = $urandom_range(1, DIGIT_LIMIT);
        lo   = 64'd1;
        repeat (ndig - 1) lo = lo * 64'd10;
        random_candidate = lo + pick % (lo * 64'd9);
      end
    end
  endfunction

  // one transaction on the query channel; entered and left at a falling edge
  task automatic send_candidate(input logic [63:0] value);
    begin
      while ($urandom_range(0, 99) < send_idle_pct) begin
        query_ch.valid     <= 1'b0;
        query_ch.candidate <= {$urandom, $urandom};
        @(negedge clk);
      end
      query_ch.valid     <= 1'b1;
      query_ch.candidate <= value;
      do @(posedge clk); while (!(query_ch.valid && query_ch.ready));
      @(negedge clk);
      sent++;
      if (value >= 64'd10000000000000000000) wide_sent++;
    end
  endtask

  initial begin
    int idx;
    int phase;
    rst                = 1'b1;
    query_ch.valid     = 1'b0;
    query_ch.candidate = '0;
    verdict_ch.ready   = 1'b0;
    send_idle_pct      = 37;
    recv_idle_pct      = 65;
    sent               = 0;
    wide_sent          = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed corners under the first idling mix
    for (idx = 0; idx < NUM_DIRECTED; idx++) send_candidate(directed_cands[idx]);

    // three idling phases: sender light / receiver heavy, swapped, then none
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 65 : 0;
      recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 37 : 0;
      for (idx = 0; idx < RANDOM_ITEMS / 3; idx++) send_candidate(random_candidate());
    end
    query_ch.valid <= 1'b0;

    // drain outstanding verdicts, then give the engine time to misbehave
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d candidates (%0d directed, %0d wider than 19 digits) in three idling phases",
             sent, NUM_DIRECTED, wide_sent);
    $display("checked %0d verdicts, %0d keith hits, %0d mismatches",
             checked, keith_hits, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/kn_pkg.sv
hw/rtl/kn_ifs.sv
hw/rtl/kn_front.sv
hw/rtl/kn_queue.sv
hw/rtl/kn_back.sv
hw/rtl/keith_number_test.sv
verif/keith_verdict_checker.sv
verif/keith_number_test_tb.sv
